// ----- src/lad_pkg.sv -----
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types, sizes and helpers for the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IO_WIDTH   = 32;

    // index runs 0..DEPTH, address runs 0..DEPTH-1
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = (DATA_WIDTH > IO_WIDTH) ? DATA_WIDTH : IO_WIDTH;

    typedef enum logic [1:0] {
        FUNC_PUSH_REAR  = 2'd0,
        FUNC_PUSH_FRONT = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } lad_func_e;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_UNDER = 2'd2
    } lad_status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } lad_state_e;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [IO_WIDTH-1:0] data_in;
    } lad_in_t;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] data_out;
        logic [1:0]                 status;
    } lad_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } lad_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rd_issue;
    } lad_stat_t;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [IO_WIDTH-1:0] d);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(d);
        return ext[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [IO_WIDTH-1:0] to_io(input logic [DATA_WIDTH-1:0] w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[IO_WIDTH-1:0];
    endfunction

endpackage

// ----- src/lad_ram.sv -----
// ----------------------------------------------------------------------------
// lad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/lad_datapath.sv -----
// ----------------------------------------------------------------------------
// lad_datapath
// Front/rear indices, entry storage and the result register of the deque.
// ----------------------------------------------------------------------------
module lad_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  lad_pkg::lad_in_t   s_data,
    input  lad_pkg::lad_cmd_t  cmd,
    output lad_pkg::lad_stat_t stat,
    output lad_pkg::lad_out_t  m_data
);
    import lad_pkg::*;

    lad_in_t                item_reg;
    logic [IDX_W-1:0]       front_reg, front_next;
    logic [IDX_W-1:0]       rear_reg, rear_next;
    logic [IO_WIDTH-1:0]    out_data_reg;
    lad_status_e            out_status_reg;

    logic                   op_we, op_re;
    logic [ADDR_W-1:0]      op_waddr, op_raddr;
    lad_status_e            op_status;
    logic [IDX_W-1:0]       front_dec, front_inc, rear_dec;
    logic [DATA_WIDTH-1:0]  rd_data;

    assign front_dec = front_reg - IDX_W'(1);
    assign front_inc = front_reg + IDX_W'(1);
    assign rear_dec  = rear_reg - IDX_W'(1);

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        op_we      = 1'b0;
        op_re      = 1'b0;
        op_waddr   = rear_reg[ADDR_W-1:0];
        op_raddr   = front_reg[ADDR_W-1:0];
        op_status  = STAT_DONE;
        unique case (lad_func_e'(item_reg.func))
            FUNC_PUSH_REAR: begin
                if (rear_reg == IDX_W'(DEPTH)) begin
                    op_status = STAT_FULL;
                end else begin
                    op_we     = 1'b1;
                    op_waddr  = rear_reg[ADDR_W-1:0];
                    rear_next = rear_reg + IDX_W'(1);
                end
            end
            FUNC_PUSH_FRONT: begin
                if (front_reg == '0) begin
                    op_status = STAT_FULL;
                end else begin
                    op_we      = 1'b1;
                    op_waddr   = front_dec[ADDR_W-1:0];
                    front_next = front_dec;
                end
            end
            FUNC_POP_FRONT: begin
                if (front_reg >= rear_reg) begin
                    op_status = STAT_UNDER;
                end else begin
                    op_re    = 1'b1;
                    op_raddr = front_reg[ADDR_W-1:0];
                    // last entry taken: both indices restart at zero
                    if (front_inc == rear_reg) begin
                        front_next = '0;
                        rear_next  = '0;
                    end else begin
                        front_next = front_inc;
                    end
                end
            end
            FUNC_POP_REAR: begin
                if (front_reg >= rear_reg) begin
                    op_status = STAT_UNDER;
                end else begin
                    op_re    = 1'b1;
                    op_raddr = rear_dec[ADDR_W-1:0];
                    if (front_reg == rear_dec) begin
                        front_next = '0;
                        rear_next  = '0;
                    end else begin
                        rear_next = rear_dec;
                    end
                end
            end
            default: begin
                op_status = STAT_DONE;
            end
        endcase
    end

    assign stat.rd_issue = cmd.exec & op_re;

    lad_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.exec & op_we),
        .waddr (op_waddr),
        .wdata (to_word(item_reg.data_in)),
        .re    (cmd.exec & op_re),
        .raddr (op_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            out_data_reg   <= '0;
            out_status_reg <= op_status;
        end else if (cmd.capture) begin
            out_data_reg <= to_io(rd_data);
        end
    end

    assign m_data.data_out = out_data_reg;
    assign m_data.status   = out_status_reg;

endmodule

// ----- src/lad_ctrl.sv -----
// ----------------------------------------------------------------------------
// lad_ctrl
// Sequencer: takes a request, runs it on the datapath, holds the result.
// ----------------------------------------------------------------------------
module lad_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lad_pkg::lad_stat_t stat,
    output lad_pkg::lad_cmd_t  cmd
);
    import lad_pkg::*;

    lad_state_e state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // pops pass through S_READ for the registered ram read
                state_next = stat.rd_issue ? S_READ : S_RESP;
            end
            S_READ: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_READ: begin
                cmd.capture = 1'b1;
            end
            S_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/linear_array_deque.sv -----
// Linear (non-circular) double-ended queue of lad_pkg::DEPTH words. Each request
// pushes at the rear or front, or pops from the front or rear, and returns exactly
// one result: the popped value, 0 with status done for a push, or 0 with status
// full or underflow. A push at the front is refused whenever the front index is 0,
// even on an empty queue; a pop that empties the queue returns both indices to 0.
// One request is handled at a time: the result of a push is registered in the
// execute state, that of a pop after a further read state, the registered read of
// the entry RAM; no new request is taken until the result has been accepted.
// ----------------------------------------------------------------------------
// linear_array_deque
// Top level: controller, datapath and interface checks.
// ----------------------------------------------------------------------------
module linear_array_deque (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lad_pkg::lad_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lad_pkg::lad_out_t m_data
);
    import lad_pkg::*;

    lad_cmd_t  cmd;
    lad_stat_t stat;

    lad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lad_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // a new request is never taken while a result is still pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !m_valid)
        else $error("request accepted while result pending");

    // read data is captured only right after a pop issued its read
    a_capture_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> $past(stat.rd_issue))
        else $error("capture without ram read");

    // rejected or underflowed requests carry zero data
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STAT_FULL || m_data.status == STAT_UNDER))
            |-> (m_data.data_out == '0))
        else $error("nonzero data on failed request");

    // a result follows each executed request that issues no ram read
    a_exec_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && !stat.rd_issue) |=> m_valid)
        else $error("push result not presented");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop requests into the linear array deque through its
// valid/ready channels and checks each result against a shadow deque kept in
// the bench or, for typed rows, the table. A short table of hand-picked
// requests comes first, then random phases: fill, drain, front or even mix.
// ----------------------------------------------------------------------------
module testbench;

    import lad_pkg::*;

    localparam int NUM_RANDOM  = 800;
    localparam int PLAN_ROWS   = 25;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_PRINTS  = 200;

    typedef struct {
        lad_in_t  req;
        bit       typed;
        lad_out_t res;
    } plan_row_t;

    typedef enum {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_FRONT
    } mix_e;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lad_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lad_out_t m_data;

    // expectation typed into the table travels beside the request
    bit       row_typed = 1'b0;
    lad_out_t row_res   = '0;

    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    logic [IDX_W-1:0]      shadow_front = '0;
    logic [IDX_W-1:0]      shadow_rear  = '0;
    lad_out_t              awaited_responses [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit hold_flag    = 1'b0;
    bit quiet_phase  = 1'b0;

    plan_row_t plan [PLAN_ROWS];

    linear_array_deque dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic lad_out_t deque_apply(input lad_in_t req);
        lad_out_t r;
        r.data_out = '0;
        r.status   = STAT_DONE;
        case (lad_func_e'(req.func))
            FUNC_PUSH_REAR: begin
                if (shadow_rear == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_words[shadow_rear[ADDR_W-1:0]] = DATA_WIDTH'($unsigned(req.data_in));
                    shadow_rear = shadow_rear + 1'b1;
                end
            end
            FUNC_PUSH_FRONT: begin
                if (shadow_front == 0) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_words[shadow_front[ADDR_W-1:0]] = DATA_WIDTH'($unsigned(req.data_in));
                end
            end
            FUNC_POP_FRONT: begin
                if (shadow_front >= shadow_rear) begin
                    r.status = STAT_UNDER;
                end else begin
                    r.data_out   = IO_WIDTH'(shadow_words[shadow_front[ADDR_W-1:0]]);
                    shadow_front = shadow_front + 1'b1;
                end
            end
            default: begin
                if (shadow_front >= shadow_rear) begin
                    r.status = STAT_UNDER;
                end else begin
                    shadow_rear = shadow_rear - 1'b1;
                    r.data_out  = IO_WIDTH'(shadow_words[shadow_rear[ADDR_W-1:0]]);
                end
            end
        endcase
        // emptied by a pop: both ends fall back to the bottom
        if (r.status == STAT_DONE && shadow_front == shadow_rear) begin
            shadow_front = '0;
            shadow_rear  = '0;
        end
        return r;
    endfunction

    function automatic plan_row_t plan_row(input lad_func_e f, input logic [31:0] d,
                                           input bit typed, input logic [31:0] dout,
                                           input lad_status_e st);
        plan_row_t p;
        p.req.func     = f;
        p.req.data_in  = d;
        p.typed        = typed;
        p.res.data_out = dout;
        p.res.status   = st;
        return p;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic lad_func_e pick_func(input mix_e mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MIX_FILL: begin
                if (r < 50) return FUNC_PUSH_REAR;
                if (r < 70) return FUNC_PUSH_FRONT;
                return (r < 85) ? FUNC_POP_FRONT : FUNC_POP_REAR;
            end
            MIX_DRAIN: begin
                if (r < 15) return FUNC_PUSH_REAR;
                if (r < 25) return FUNC_PUSH_FRONT;
                return (r < 62) ? FUNC_POP_FRONT : FUNC_POP_REAR;
            end
            MIX_FRONT: begin
                if (r < 40) return FUNC_POP_FRONT;
                if (r < 75) return FUNC_PUSH_FRONT;
                return (r < 90) ? FUNC_PUSH_REAR : FUNC_POP_REAR;
            end
            default: return lad_func_e'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // holds valid until the request is taken
    task automatic offer(input lad_in_t req, input bit typed, input lad_out_t res);
        int gap;
        gap = quiet_phase ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= req;
        row_typed <= typed;
        row_res   <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_responses.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : monitor
        lad_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = deque_apply(s_data);
                if (row_typed) want = row_res;
                awaited_responses.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (awaited_responses.size() == 0) begin
                    report_mismatch($sformatf("result %h/%0d with nothing awaited",
                                              m_data.data_out, m_data.status));
                end else begin
                    want = awaited_responses.pop_front();
                    if (m_data.data_out !== want.data_out)
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  m_data.data_out, want.data_out));
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_data.status, want.status));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    initial begin : receiver
        int burst;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_flag) begin
                // long back-pressure so the deque stops taking requests
                hold_flag = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
                m_ready <= 1'b1;
                repeat (burst) @(posedge aclk);
                gap = idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : sender
        logic [31:0] fill_vals [16];
        lad_in_t     req;
        lad_out_t    none;
        mix_e        mode;
        int          left_in_phase;

        fill_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                      32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'hfffe_0001,
                      32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h7fff_fffe, 32'h8000_0001,
                      32'h1357_9bdf, 32'heca8_6420, 32'h0001_0000, 32'hdead_beef};

        // empty deque right after reset, then a push at the front with front at 0
        plan[0] = plan_row(FUNC_POP_FRONT, 32'h0, 1, 32'h0, STAT_UNDER);
        plan[1] = plan_row(FUNC_POP_REAR, 32'h1234_5678, 1, 32'h0, STAT_UNDER);
        plan[2] = plan_row(FUNC_PUSH_FRONT, 32'h5555_5555, 1, 32'h0, STAT_FULL);
        for (int i = 0; i < 16; i++)
            plan[3 + i] = plan_row(FUNC_PUSH_REAR, fill_vals[i], 0, 32'h0, STAT_DONE);
        // rear at the top, front still at the bottom
        plan[19] = plan_row(FUNC_PUSH_REAR, 32'h0bad_f00d, 1, 32'h0, STAT_FULL);
        plan[20] = plan_row(FUNC_PUSH_FRONT, 32'hffff_ffff, 1, 32'h0, STAT_FULL);
        plan[21] = plan_row(FUNC_POP_FRONT, 32'h0, 1, 32'h7fff_ffff, STAT_DONE);
        plan[22] = plan_row(FUNC_PUSH_FRONT, 32'h8000_0001, 0, 32'h0, STAT_DONE);
        plan[23] = plan_row(FUNC_POP_REAR, 32'h0, 0, 32'h0, STAT_DONE);
        plan[24] = plan_row(FUNC_POP_FRONT, 32'h0, 0, 32'h0, STAT_DONE);

        none = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++)
            offer(plan[i].req, plan[i].typed, plan[i].res);

        left_in_phase = 0;
        mode = MIX_EVEN;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (left_in_phase == 0) begin
                left_in_phase = $urandom_range(20, 80);
                mode          = mix_e'($urandom_range(0, 3));
                quiet_phase   = ($urandom_range(0, 3) == 0);
            end
            left_in_phase--;
            if (n == 200) hold_flag = 1'b1;
            if (n == 450) wait_until_drained();
            req.func    = pick_func(mode);
            req.data_in = pick_word();
            offer(req, 1'b0, none);
        end

        wait_until_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
